// File: design/glfc_pkg.sv
package glfc_pkg;

  localparam logic [7:0] SYNC_A = 8'hAA;
  localparam logic [7:0] SYNC_B = 8'h44;
  localparam logic [7:0] SYNC_C = 8'h12;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  localparam int OFFSET_W = 17;
  localparam int LEN_W    = 16;
  localparam int ID_W     = 16;

  // header layout, offsets from the first sync byte
  localparam logic [OFFSET_W-1:0] OFS_SYNC_A   = 17'd0;
  localparam logic [OFFSET_W-1:0] OFS_SYNC_B   = 17'd1;
  localparam logic [OFFSET_W-1:0] OFS_SYNC_C   = 17'd2;
  localparam logic [OFFSET_W-1:0] OFS_FIRST    = 17'd3;
  localparam logic [OFFSET_W-1:0] OFS_ID_LO    = 17'd4;
  localparam logic [OFFSET_W-1:0] OFS_ID_HI    = 17'd5;
  localparam logic [OFFSET_W-1:0] OFS_LEN_LO   = 17'd8;
  localparam logic [OFFSET_W-1:0] OFS_LEN_HI   = 17'd9;
  localparam logic [OFFSET_W-1:0] OFS_WEEK_LO  = 17'd14;
  localparam logic [OFFSET_W-1:0] OFS_WEEK_HI  = 17'd15;
  localparam logic [OFFSET_W-1:0] OFS_MS_B0    = 17'd16;
  localparam logic [OFFSET_W-1:0] OFS_MS_B1    = 17'd17;
  localparam logic [OFFSET_W-1:0] OFS_MS_B2    = 17'd18;
  localparam logic [OFFSET_W-1:0] OFS_MS_B3    = 17'd19;
  localparam logic [OFFSET_W-1:0] HEADER_BYTES = 17'd28;
  localparam logic [OFFSET_W-1:0] LAST_FROM_LEN = 17'd31;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] REG_OBSERVATION = 2'd0;
  localparam logic [1:0] REG_GPS_EPH     = 2'd1;
  localparam logic [1:0] REG_BDS_EPH     = 2'd2;
  localparam logic [1:0] REG_POSITION    = 2'd3;

  localparam logic [ID_W-1:0] RST_OBSERVATION = 16'd43;
  localparam logic [ID_W-1:0] RST_GPS_EPH     = 16'd7;
  localparam logic [ID_W-1:0] RST_BDS_EPH     = 16'd1696;
  localparam logic [ID_W-1:0] RST_POSITION    = 16'd42;

  typedef enum logic [2:0] {
    KIND_OTHER       = 3'd0,
    KIND_OBSERVATION = 3'd1,
    KIND_GPS_EPH     = 3'd2,
    KIND_BDS_EPH     = 3'd3,
    KIND_POSITION    = 3'd4
  } msg_kind_t;

  typedef enum logic [3:0] {
    ST_HUNT   = 4'b0001,
    ST_SEEN_A = 4'b0010,
    ST_SEEN_B = 4'b0100,
    ST_FRAME  = 4'b1000
  } sync_state_t;

  typedef struct packed {
    logic [ID_W-1:0] observation;
    logic [ID_W-1:0] gps_eph;
    logic [ID_W-1:0] bds_eph;
    logic [ID_W-1:0] position;
  } cfg_t;

  // one classified frame byte, handed from the front to the back
  typedef struct packed {
    logic [7:0]          data;
    logic [OFFSET_W-1:0] offset;
    logic                trailer;  // byte of the received CRC
    logic [1:0]          lane;     // byte position inside the received CRC
    logic                last;
  } item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/glfc_front.sv
module glfc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  output logic                push,
  output glfc_pkg::item_t     push_item,
  input  logic                fifo_full
);
  import glfc_pkg::*;

  sync_state_t         state;
  sync_state_t         state_next;
  logic [OFFSET_W-1:0] byte_index;
  logic [OFFSET_W-1:0] byte_index_next;
  logic [LEN_W-1:0]    payload_length;
  logic [LEN_W-1:0]    payload_length_next;

  logic                in_fire;
  logic                emit;
  logic [OFFSET_W-1:0] trailer_start;
  logic [OFFSET_W-1:0] last_index;

  assign in_ready = !fifo_full;
  assign in_fire  = in_valid && in_ready;

  // payload length is final well before the trailer can begin
  assign trailer_start = {1'b0, payload_length} + HEADER_BYTES;
  assign last_index    = {1'b0, payload_length} + LAST_FROM_LEN;

  always_comb begin
    state_next          = state;
    byte_index_next     = byte_index;
    payload_length_next = payload_length;
    emit                = 1'b0;
    push_item           = '0;
    push_item.data      = in_byte;
    unique case (state) inside
      ST_HUNT: begin
        if (in_byte == SYNC_A) begin
          emit             = 1'b1;
          push_item.offset = OFS_SYNC_A;
          state_next       = ST_SEEN_A;
        end
      end
      ST_SEEN_A, ST_SEEN_B: begin
        if (state == ST_SEEN_A && in_byte == SYNC_B) begin
          emit             = 1'b1;
          push_item.offset = OFS_SYNC_B;
          state_next       = ST_SEEN_B;
        end else if (state == ST_SEEN_B && in_byte == SYNC_C) begin
          emit                = 1'b1;
          push_item.offset    = OFS_SYNC_C;
          state_next          = ST_FRAME;
          byte_index_next     = OFS_FIRST;
          payload_length_next = '0;
        end else if (in_byte == SYNC_A) begin
          // restart the hunt on this byte
          emit             = 1'b1;
          push_item.offset = OFS_SYNC_A;
          state_next       = ST_SEEN_A;
        end else begin
          state_next = ST_HUNT;
        end
      end
      ST_FRAME: begin
        emit              = 1'b1;
        push_item.offset  = byte_index;
        push_item.trailer = (byte_index >= trailer_start);
        push_item.lane    = byte_index[1:0] - payload_length[1:0];
        push_item.last    = (byte_index == last_index);
        if (byte_index == OFS_LEN_LO) begin
          payload_length_next = {8'd0, in_byte};
        end else if (byte_index == OFS_LEN_HI) begin
          payload_length_next = {in_byte, payload_length[7:0]};
        end
        if (push_item.last) begin
          state_next      = ST_HUNT;
          byte_index_next = '0;
        end else begin
          byte_index_next = byte_index + 1'b1;
        end
      end
      default: state_next = ST_HUNT;
    endcase
  end

  assign push = in_fire && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_HUNT;
      byte_index     <= '0;
      payload_length <= '0;
    end else if (in_fire) begin
      state          <= state_next;
      byte_index     <= byte_index_next;
      payload_length <= payload_length_next;
    end
  end

endmodule

// File: design/glfc_fifo.sv
module glfc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  glfc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output glfc_pkg::item_t pop_item
);
  import glfc_pkg::*;

  item_t                 entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full      = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/glfc_back.sv
module glfc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  glfc_pkg::cfg_t              cfg,
  input  logic                        item_valid,
  input  glfc_pkg::item_t             item,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic [glfc_pkg::OFFSET_W-1:0] out_offset,
  output logic                        out_last,
  output logic                        out_good,
  output glfc_pkg::msg_kind_t         out_kind,
  output logic [glfc_pkg::ID_W-1:0]   out_code,
  output logic [15:0]                 out_week,
  output logic signed [31:0]          out_millis
);
  import glfc_pkg::*;

  logic [31:0]     running_crc;
  logic [31:0]     running_crc_next;
  logic [31:0]     received_crc;
  logic [31:0]     received_crc_next;
  logic [ID_W-1:0] captured_id;
  logic [ID_W-1:0] captured_id_next;
  logic [15:0]     captured_week;
  logic [15:0]     captured_week_next;
  logic [31:0]     captured_millis;
  logic [31:0]     captured_millis_next;

  logic [31:0]     crc_base;
  logic            frame_start;
  msg_kind_t       kind;

  assign pop = item_valid && (!out_valid || out_ready);

  assign frame_start = (item.offset == OFS_SYNC_C);
  assign crc_base    = (item.offset == OFS_SYNC_A) ? 32'd0 : running_crc;

  always_comb begin
    captured_id_next     = frame_start ? '0 : captured_id;
    captured_week_next   = frame_start ? '0 : captured_week;
    captured_millis_next = frame_start ? '0 : captured_millis;
    received_crc_next    = frame_start ? '0 : received_crc;
    case (item.offset)
      OFS_ID_LO:   captured_id_next = {8'd0, item.data};
      OFS_ID_HI:   captured_id_next = {item.data, captured_id[7:0]};
      OFS_WEEK_LO: captured_week_next = {8'd0, item.data};
      OFS_WEEK_HI: captured_week_next = {item.data, captured_week[7:0]};
      OFS_MS_B0:   captured_millis_next = {24'd0, item.data};
      OFS_MS_B1:   captured_millis_next = captured_millis | {16'd0, item.data, 8'd0};
      OFS_MS_B2:   captured_millis_next = captured_millis | {8'd0, item.data, 16'd0};
      OFS_MS_B3:   captured_millis_next = captured_millis | {item.data, 24'd0};
      default: ;
    endcase
    if (item.trailer) begin
      running_crc_next = running_crc;
      case (item.lane)
        2'd0:    received_crc_next = received_crc | {24'd0, item.data};
        2'd1:    received_crc_next = received_crc | {16'd0, item.data, 8'd0};
        2'd2:    received_crc_next = received_crc | {8'd0, item.data, 16'd0};
        default: received_crc_next = received_crc | {item.data, 24'd0};
      endcase
    end else begin
      running_crc_next = crc_byte(crc_base, item.data);
    end
  end

  // first match wins
  always_comb begin
    if (captured_id == cfg.observation) begin
      kind = KIND_OBSERVATION;
    end else if (captured_id == cfg.gps_eph) begin
      kind = KIND_GPS_EPH;
    end else if (captured_id == cfg.bds_eph) begin
      kind = KIND_BDS_EPH;
    end else if (captured_id == cfg.position) begin
      kind = KIND_POSITION;
    end else begin
      kind = KIND_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      running_crc     <= '0;
      received_crc    <= '0;
      captured_id     <= '0;
      captured_week   <= '0;
      captured_millis <= '0;
    end else begin
      if (pop) begin
        out_valid       <= 1'b1;
        running_crc     <= running_crc_next;
        received_crc    <= received_crc_next;
        captured_id     <= captured_id_next;
        captured_week   <= captured_week_next;
        captured_millis <= captured_millis_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte   <= item.data;
      out_offset <= item.offset;
      out_last   <= item.last;
      out_good   <= item.last && (received_crc_next == running_crc);
      out_kind   <= item.last ? kind : KIND_OTHER;
      out_code   <= captured_id_next;
      out_week   <= captured_week_next;
      out_millis <= captured_millis_next;
    end
  end

endmodule

// File: design/gnss_binary_log_framer_crc32_unit.sv
// Path: an accepted byte is written into the queue, then registered onto the output
// by the back end. Throughput: one byte per cycle while the queue has room and the
// output is taken; the per-byte CRC-32 update is unrolled over eight bit steps in
// the back end, and a four-entry queue sits between front and back.
// Bytes that break or do not start a sync sequence give no result, except an AA.
// Reset (rst, synchronous): hunt for sync, clear queue, fields and CRC, load default IDs.
module gnss_binary_log_framer_crc32_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] frame_byte, [24:8] frame_offset, [40:25] message_code,
  // [56:41] gps_week, [88:57] week_millis, [95:89] zero
  output logic [95:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,   // [0] crc_good, [3:1] message_kind
  output logic        m_axis_tlast,   // last_byte
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import glfc_pkg::*;

  cfg_t                cfg;
  logic                push;
  item_t               push_item;
  logic                fifo_full;
  logic                pop;
  logic                fifo_not_empty;
  item_t               pop_item;
  logic [7:0]          frame_byte;
  logic [OFFSET_W-1:0] frame_offset;
  logic                crc_good;
  msg_kind_t           message_kind;
  logic [ID_W-1:0]     message_code;
  logic [15:0]         gps_week;
  logic signed [31:0]  week_millis;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.observation <= RST_OBSERVATION;
      cfg.gps_eph     <= RST_GPS_EPH;
      cfg.bds_eph     <= RST_BDS_EPH;
      cfg.position    <= RST_POSITION;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OBSERVATION: cfg.observation <= cfg_data;
        REG_GPS_EPH:     cfg.gps_eph     <= cfg_data;
        REG_BDS_EPH:     cfg.bds_eph     <= cfg_data;
        REG_POSITION:    cfg.position    <= cfg_data;
        default: ;
      endcase
    end
  end

  glfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .push      (push),
    .push_item (push_item),
    .fifo_full (fifo_full)
  );

  glfc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (fifo_full),
    .pop       (pop),
    .not_empty (fifo_not_empty),
    .pop_item  (pop_item)
  );

  glfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (fifo_not_empty),
    .item       (pop_item),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (frame_byte),
    .out_offset (frame_offset),
    .out_last   (m_axis_tlast),
    .out_good   (crc_good),
    .out_kind   (message_kind),
    .out_code   (message_code),
    .out_week   (gps_week),
    .out_millis (week_millis)
  );

  assign m_axis_tdata = {7'd0, week_millis, gps_week, message_code, frame_offset, frame_byte};
  assign m_axis_tuser = {message_kind, crc_good};

`ifndef SYNTH
  // the final byte sits at least past header and trailer
  a_last_offset: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> frame_offset >= LAST_FROM_LEN)
    else $error("last byte at an offset inside the header");

  a_status_only_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !crc_good && message_kind == KIND_OTHER)
    else $error("CRC status or class shown before the last byte");

  a_frame_opens_sync: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && frame_offset == OFS_SYNC_A |-> frame_byte == SYNC_A)
    else $error("frame opened on a byte other than the first sync byte");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_full)
    else $error("byte pushed into a full queue");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import glfc_pkg::*;

  localparam int CRC_LEN = 4;
  localparam logic [1:0] REG_ORDER[4] = '{REG_OBSERVATION, REG_GPS_EPH, REG_BDS_EPH,
                                          REG_POSITION};

  typedef struct packed {
    logic [7:0]          fbyte;
    logic [OFFSET_W-1:0] offset;
    logic                last;
    logic                good;
    msg_kind_t           kind;
    logic [ID_W-1:0]     code;
    logic [15:0]         week;
    logic [31:0]         millis;
  } frame_rec_t;

  typedef struct {
    logic [7:0]          rx;
    bit                  echoed;
    logic [OFFSET_W-1:0] offset;
  } probe_row_t;

  // hunt behavior straight after reset: all captured fields are still zero
  probe_row_t hunt_probes[14] = '{
    '{8'h00, 1'b0, 17'd0},
    '{8'hFF, 1'b0, 17'd0},
    '{8'hAA, 1'b1, 17'd0},
    '{8'h55, 1'b0, 17'd0},
    '{8'hAA, 1'b1, 17'd0},
    '{8'hAA, 1'b1, 17'd0},
    '{8'h44, 1'b1, 17'd1},
    '{8'h44, 1'b0, 17'd0},
    '{8'hAA, 1'b1, 17'd0},
    '{8'h44, 1'b1, 17'd1},
    '{8'hAA, 1'b1, 17'd0},
    '{8'h44, 1'b1, 17'd1},
    '{8'h80, 1'b0, 17'd0},
    '{8'h7F, 1'b0, 17'd0}
  };

  logic [15:0] class_sets[4][4] = '{
    '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF},
    '{16'd5, 16'd5, 16'd5, 16'd5},
    '{16'd100, 16'd200, 16'd200, 16'd200},
    '{16'd300, 16'd400, 16'd500, 16'd500}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_OBSERVATION;
  logic [15:0] cfg_data = 16'h0000;

  // deframer state as the testbench sees it
  sync_state_t         hunt_state;
  logic [OFFSET_W-1:0] next_ofs;
  logic [15:0]         cap_id, cap_len, cap_week;
  logic [31:0]         cap_ms, crc_acc, crc_rx;
  logic [15:0]         class_id[4];

  frame_rec_t  pending_echoes[$];
  bit          burst = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned hold_cycles = 0;
  int unsigned mismatches = 0;

  gnss_binary_log_framer_crc32_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] s;
    bit          fb;
    s = c;
    for (int i = 0; i < 8; i++) begin
      fb = s[0] ^ d[i];
      s = s >> 1;
      if (fb) begin
        s = s ^ CRC_POLY;
      end
    end
    return s;
  endfunction

  // advance the deframer by one byte; returns 1 when the byte is echoed
  function automatic bit predict_deframe(input logic [7:0] b, output frame_rec_t r);
    logic [OFFSET_W-1:0] idx, last_ofs;
    logic [1:0]          lane;
    bit                  echo;
    r = '0;
    r.fbyte = b;
    echo = 1'b1;
    if (hunt_state == ST_SEEN_A && b == SYNC_B) begin
      hunt_state = ST_SEEN_B;
      crc_acc = crc_step(crc_acc, b);
      r.offset = OFS_SYNC_B;
    end else if (hunt_state == ST_SEEN_B && b == SYNC_C) begin
      hunt_state = ST_FRAME;
      next_ofs = OFS_FIRST;
      crc_acc = crc_step(crc_acc, b);
      cap_id = '0;
      cap_len = '0;
      cap_week = '0;
      cap_ms = '0;
      crc_rx = '0;
      r.offset = OFS_SYNC_C;
    end else if (hunt_state != ST_FRAME) begin
      // any break in the sync sequence restarts the hunt; AA counts as a fresh start
      if (b == SYNC_A) begin
        hunt_state = ST_SEEN_A;
        crc_acc = crc_step(32'h0, b);
        r.offset = OFS_SYNC_A;
      end else begin
        hunt_state = ST_HUNT;
        crc_acc = '0;
        echo = 1'b0;
      end
    end else begin
      idx = next_ofs;
      case (idx)
        OFS_ID_LO:   cap_id = {8'h00, b};
        OFS_ID_HI:   cap_id[15:8] = b;
        OFS_LEN_LO:  cap_len = {8'h00, b};
        OFS_LEN_HI:  cap_len[15:8] = b;
        OFS_WEEK_LO: cap_week = {8'h00, b};
        OFS_WEEK_HI: cap_week[15:8] = b;
        OFS_MS_B0:   cap_ms = {24'h0, b};
        OFS_MS_B1:   cap_ms[15:8] = b;
        OFS_MS_B2:   cap_ms[23:16] = b;
        OFS_MS_B3:   cap_ms[31:24] = b;
        default: ;
      endcase
      last_ofs = {1'b0, cap_len} + LAST_FROM_LEN;
      if (idx > last_ofs - CRC_LEN) begin
        lane = 2'(idx - (last_ofs - (CRC_LEN - 1)));
        crc_rx = crc_rx | ({24'h0, b} << (8 * lane));
      end else begin
        crc_acc = crc_step(crc_acc, b);
      end
      r.offset = idx;
      r.last = (idx == last_ofs);
      if (r.last) begin
        r.good = (crc_rx == crc_acc);
        if (cap_id == class_id[REG_OBSERVATION]) r.kind = KIND_OBSERVATION;
        else if (cap_id == class_id[REG_GPS_EPH]) r.kind = KIND_GPS_EPH;
        else if (cap_id == class_id[REG_BDS_EPH]) r.kind = KIND_BDS_EPH;
        else if (cap_id == class_id[REG_POSITION]) r.kind = KIND_POSITION;
        hunt_state = ST_HUNT;
        next_ofs = '0;
        crc_acc = '0;
      end else begin
        next_ofs = idx + 1'b1;
      end
    end
    r.code = cap_id;
    r.week = cap_week;
    r.millis = cap_ms;
    return echo;
  endfunction

  function automatic string show(input frame_rec_t r);
    return $sformatf("byte=%h ofs=%0d last=%b good=%b kind=%0d id=%h week=%h ms=%0d",
                     r.fbyte, r.offset, r.last, r.good, r.kind, r.code, r.week,
                     $signed(r.millis));
  endfunction

  task automatic check_echo();
    frame_rec_t got, want;
    got.fbyte = m_axis_tdata[7:0];
    got.offset = m_axis_tdata[24:8];
    got.code = m_axis_tdata[40:25];
    got.week = m_axis_tdata[56:41];
    got.millis = m_axis_tdata[88:57];
    got.good = m_axis_tuser[0];
    got.kind = msg_kind_t'(m_axis_tuser[3:1]);
    got.last = m_axis_tlast;
    if (pending_echoes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected transaction: %s", show(got));
      return;
    end
    want = pending_echoes.pop_front();
    if (got.fbyte !== want.fbyte || got.offset !== want.offset || got.last !== want.last ||
        got.good !== want.good || got.kind !== want.kind || got.code !== want.code ||
        got.week !== want.week || got.millis !== want.millis ||
        m_axis_tdata[95:89] !== 7'h00) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected %s", show(want));
        $display("          actual   %s pad=%h", show(got), m_axis_tdata[95:89]);
      end
    end
  endtask

  // output side: after a transaction outside a burst, drop ready at random for a drawn stall
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      check_echo();
      hold_cycles <= burst ? 0 : $urandom_range(0, 10);
      if (!burst && $urandom_range(0, 1) == 1) begin
        m_axis_tready <= 1'b0;
      end
    end else if (!m_axis_tready) begin
      if (hold_cycles <= 1) m_axis_tready <= 1'b1;
      else hold_cycles <= hold_cycles - 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, output bit echo, output frame_rec_t rec);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    echo = predict_deframe(b, rec);
    bytes_sent++;
  endtask

  task automatic feed(input logic [7:0] b);
    bit         echo;
    frame_rec_t rec;
    send_byte(b, echo, rec);
    if (echo) pending_echoes.push_back(rec);
  endtask

  task automatic send_frame(input logic [15:0] id, input logic [15:0] plen, input bit bad_crc,
                            input bit sync_inside);
    logic [7:0]  fb[$];
    logic [31:0] c, ms;
    logic [15:0] wk;
    int unsigned k, at;
    wk = 16'($urandom);
    ms = $urandom;
    fb = {SYNC_A, SYNC_B, SYNC_C};
    for (k = OFS_FIRST; k < HEADER_BYTES; k++) fb.push_back(8'($urandom_range(0, 255)));
    fb[OFS_ID_LO] = id[7:0];
    fb[OFS_ID_HI] = id[15:8];
    fb[OFS_LEN_LO] = plen[7:0];
    fb[OFS_LEN_HI] = plen[15:8];
    fb[OFS_WEEK_LO] = wk[7:0];
    fb[OFS_WEEK_HI] = wk[15:8];
    fb[OFS_MS_B0] = ms[7:0];
    fb[OFS_MS_B1] = ms[15:8];
    fb[OFS_MS_B2] = ms[23:16];
    fb[OFS_MS_B3] = ms[31:24];
    for (k = 0; k < plen; k++) fb.push_back(8'($urandom_range(0, 255)));
    // a sync pattern inside the payload must not restart the frame
    if (sync_inside && plen >= 3) begin
      at = HEADER_BYTES + $urandom_range(0, plen - 3);
      fb[at] = SYNC_A;
      fb[at + 1] = SYNC_B;
      fb[at + 2] = SYNC_C;
    end
    c = '0;
    foreach (fb[i]) c = crc_step(c, fb[i]);
    if (bad_crc) c = c ^ (32'h1 << $urandom_range(0, 31));
    for (k = 0; k < CRC_LEN; k++) fb.push_back(c[8 * k +: 8]);
    foreach (fb[i]) feed(fb[i]);
    burst = 1'b0;
  endtask

  task automatic run_mix(input int unsigned quota);
    int unsigned start, pick, k, n, plen;
    logic [15:0] id;
    logic [7:0]  b;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        k = $urandom_range(0, 5);
        if (k < 4) id = class_id[k];
        else if (k == 4) id = 16'($urandom);
        else id = class_id[REG_OBSERVATION] + 16'd1;
        plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
        burst = ($urandom_range(0, 5) == 0);
        send_frame(id, 16'(plen), $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
      end else if (pick == 7) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          b = 8'($urandom_range(0, 255));
          // keep noise from completing a sync sequence
          if (hunt_state == ST_SEEN_B && b == SYNC_C) b = ~b;
          feed(b);
        end
      end else begin
        feed(SYNC_A);
        if (pick == 9) feed(SYNC_B);
        do b = 8'($urandom_range(0, 255)); while (b == ((pick == 9) ? SYNC_C : SYNC_B));
        feed(b);
      end
    end
  endtask

  // drop valid and wait for the block to drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_echoes.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic load_class_ids(input logic [15:0] v[4]);
    cfg_wr_en <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_index <= REG_ORDER[k];
      cfg_data <= v[k];
      @(posedge clk);
      class_id[REG_ORDER[k]] = v[k];
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    frame_rec_t  rec, pinned;
    bit          echo;
    logic [15:0] ids[4];
    hunt_state = ST_HUNT;
    next_ofs = '0;
    cap_id = '0;
    cap_len = '0;
    cap_week = '0;
    cap_ms = '0;
    crc_acc = '0;
    crc_rx = '0;
    class_id[REG_OBSERVATION] = RST_OBSERVATION;
    class_id[REG_GPS_EPH] = RST_GPS_EPH;
    class_id[REG_BDS_EPH] = RST_BDS_EPH;
    class_id[REG_POSITION] = RST_POSITION;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (hunt_probes[i]) begin
      send_byte(hunt_probes[i].rx, echo, rec);
      if (hunt_probes[i].echoed) begin
        pinned = '0;
        pinned.fbyte = hunt_probes[i].rx;
        pinned.offset = hunt_probes[i].offset;
        pinned.kind = KIND_OTHER;
        pending_echoes.push_back(pinned);
      end
    end
    send_frame(RST_OBSERVATION, 16'd0, 1'b0, 1'b0);
    send_frame(RST_POSITION, 16'd3, 1'b1, 1'b1);
    send_frame(16'hFFFF, 16'd1, 1'b0, 1'b0);
    send_frame(RST_BDS_EPH, 16'd2, 1'b0, 1'b0);
    run_mix(50);

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      if (ph < 4) begin
        ids = class_sets[ph];
      end else begin
        foreach (ids[k]) ids[k] = 16'($urandom);
      end
      load_class_ids(ids);
      run_mix(50);
      if (ph == 4) begin
        // frame with a nonzero high length byte, sent back to back
        burst = 1'b1;
        send_frame(class_id[REG_GPS_EPH], 16'h0100, 1'b0, 1'b0);
      end
    end
    settle();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && pending_echoes.size() == 0) begin
      $display("[gnss_binary_log_framer_crc32_unit] OK");
    end else begin
      $display("[gnss_binary_log_framer_crc32_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[gnss_binary_log_framer_crc32_unit] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
design/glfc_pkg.sv
design/glfc_front.sv
design/glfc_fifo.sv
design/glfc_back.sv
design/gnss_binary_log_framer_crc32_unit.sv
tb/sv/tb.sv
